[hw/rtl/swm_pkg.sv]
package swm_pkg;

    // width of the window size register
    localparam int CFG_BITS = 7;

    // lowest window that can be set, a zero is read as this
    localparam int MIN_WINDOW = 1;

endpackage

[hw/rtl/swm_cell.sv]
module swm_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_tok,
    input  logic [SAMPLE_BITS-1:0] i_max,
    input  logic                   i_stop,
    output logic [SAMPLE_BITS-1:0] o_sample,
    output logic                   o_tok,
    output logic                   o_tok_fwd,
    output logic [SAMPLE_BITS-1:0] o_max
);

    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] n_sample;
    logic                   r_tok;
    logic [SAMPLE_BITS-1:0] r_max;
    logic [SAMPLE_BITS-1:0] n_max;

    // sample seen by a token this cycle, the shifted one while shifting
    assign n_sample = i_shift ? i_sample : r_sample;
    assign n_max    = ($signed(n_sample) > $signed(i_max)) ? n_sample : i_max;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
        if (i_tok) begin
            r_max <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    assign o_sample  = r_sample;
    assign o_tok     = r_tok;
    assign o_tok_fwd = r_tok & ~i_stop;
    assign o_max     = r_max;

endmodule

[hw/rtl/sliding_window_maximum_core.sv]
// result: a window-filling sample sends a max token one cell a cycle from the newest cell
//   to cell w, w the effective window size (1..MAX_WINDOW), then into the output register
// throughput: one sample per cycle while the window is not yet full and the output slot
//   is free; once full, the next sample waits for the max token to reach cell w
// reset: synchronous active low, window size back to 1, stream empty, no result pending
module sliding_window_maximum_core
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write channel
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [CFG_BITS-1:0]                   i_cfg_data,   // window_size
    // sample stream in
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata, // sample, zero pad
    input  logic                                  s_axis_tlast, // stream_end
    // result stream out
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]      m_axis_tdata  // window_max, zero pad
);

    localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int FW  = $clog2(MAX_WINDOW + 1);
    localparam int WW  = (FW > CFG_BITS) ? FW : CFG_BITS;

    // most negative sample, seed of the running maximum
    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // configuration and stream bookkeeping
    logic [CFG_BITS-1:0]    r_cfg;
    logic [FW-1:0]          r_fill;
    logic [FW-1:0]          n_fill_inc;
    logic [WW-1:0]          cfg_x;
    logic [WW-1:0]          w_x;
    logic [FW-1:0]          w_eff;
    logic                   r_scan;
    logic                   accept;
    logic                   produce;

    // cell row wiring, index 0 is the newest sample
    logic [SAMPLE_BITS-1:0] c_sample [MAX_WINDOW];
    logic                   c_tok    [MAX_WINDOW];
    logic                   c_fwd    [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] c_max    [MAX_WINDOW];
    logic                   c_stop   [MAX_WINDOW];

    // result picked off the cell that closes the window
    logic                   done;
    logic [SAMPLE_BITS-1:0] done_max;
    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_max;

    // effective window: zero reads as one, large values clip to the row length
    assign cfg_x = WW'(r_cfg);
    always_comb begin
        if (cfg_x == '0) begin
            w_x = WW'(MIN_WINDOW);
        end else if (cfg_x > WW'(MAX_WINDOW)) begin
            w_x = WW'(MAX_WINDOW);
        end else begin
            w_x = cfg_x;
        end
    end
    assign w_eff = w_x[FW-1:0];

    // fill count saturates at the row length
    assign n_fill_inc = (r_fill == FW'(MAX_WINDOW)) ? r_fill : r_fill + FW'(1);

    // one sample in flight at a time once the window is full, output slot must be free
    assign s_axis_tready = ~r_scan & (~r_out_valid | m_axis_tready);
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign produce       = accept & (n_fill_inc >= w_eff);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg  <= CFG_BITS'(MIN_WINDOW);
            r_fill <= '0;
            r_scan <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_cfg <= i_cfg_data;
            end
            if (accept) begin
                // stream end empties the window after this sample is counted
                r_fill <= s_axis_tlast ? '0 : n_fill_inc;
            end
            if (produce) begin
                r_scan <= 1'b1;
            end else if (done) begin
                r_scan <= 1'b0;
            end
        end
    end

    // row of cells: samples shift on each request, a max token walks the row
    // from the newest sample until it reaches the cell that closes the window
    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        localparam logic [FW-1:0] POS = FW'(g + 1);

        logic [SAMPLE_BITS-1:0] up_sample;
        logic                   up_tok;
        logic [SAMPLE_BITS-1:0] up_max;

        if (g == 0) begin : g_head
            assign up_sample = s_axis_tdata[SAMPLE_BITS-1:0];
            assign up_tok    = produce;
            assign up_max    = MOST_NEG;
        end else begin : g_body
            assign up_sample = c_sample[g-1];
            assign up_tok    = c_fwd[g-1];
            assign up_max    = c_max[g-1];
        end

        assign c_stop[g] = (w_eff == POS);

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (accept),
            .i_sample  (up_sample),
            .i_tok     (up_tok),
            .i_max     (up_max),
            .i_stop    (c_stop[g]),
            .o_sample  (c_sample[g]),
            .o_tok     (c_tok[g]),
            .o_tok_fwd (c_fwd[g]),
            .o_max     (c_max[g])
        );
    end

    // and-or pick of the finishing cell, only one token is ever live
    always_comb begin
        done     = 1'b0;
        done_max = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            if (c_tok[k] && c_stop[k]) begin
                done     = 1'b1;
                done_max = done_max | c_max[k];
            end
        end
    end

    // output register, parts the row from the downstream stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (done) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out_max <= done_max;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = TDW'(r_out_max);

endmodule
